/* rtl/glb_container_deframer_assert.svh */
// Assertion macros for the GLB container deframer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef GLB_CONTAINER_DEFRAMER_ASSERT_SVH
`define GLB_CONTAINER_DEFRAMER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define GLBD_ASSERT_IMPL(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define GLBD_ASSERT_NEXT(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

/* rtl/glbd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the GLB container deframer.
// No dependencies; imported by glbd_step and glb_container_deframer.
package glbd_pkg;

	localparam logic [31:0] GLB_MAGIC     = 32'h4654_6C67;
	localparam logic [31:0] GLB_TYPE_JSON = 32'h4E4F_534A;
	localparam logic [31:0] GLB_TYPE_BIN  = 32'h004E_4942;
	localparam logic [31:0] GLB_HDR_LEN   = 32'd12;
	localparam logic [31:0] GLB_VERSION   = 32'd2;

	// Header byte positions: the first byte, and where each word completes.
	localparam logic [32:0] POS_FIRST   = 33'd0;
	localparam logic [32:0] POS_MAGIC   = 33'd3;
	localparam logic [32:0] POS_VERSION = 33'd7;
	localparam logic [32:0] POS_LENGTH  = 33'd11;

	// Chunk header byte offsets where a word completes.
	localparam logic [2:0] CHDR_LEN_END  = 3'd3;
	localparam logic [2:0] CHDR_TYPE_END = 3'd7;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_CHDR    = 6'b000010,
		PH_PAYLOAD = 6'b000100,
		PH_PAD     = 6'b001000,
		PH_TRAIL   = 6'b010000,
		PH_STOP    = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		K_HEADER = 3'd0,
		K_CHDR   = 3'd1,
		K_JSON   = 3'd2,
		K_BIN    = 3'd3,
		K_OTHER  = 3'd4,
		K_PAD    = 3'd5,
		K_IGN    = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_RUN      = 3'd0,
		ST_OK       = 3'd1,
		ST_SMALL    = 3'd2,
		ST_MAGIC    = 3'd3,
		ST_VERSION  = 3'd4,
		ST_LENGTH   = 3'd5,
		ST_OVERFLOW = 3'd6,
		ST_NO_JSON  = 3'd7
	} status_t;

	typedef struct packed {
		phase_t      phase;
		logic [32:0] position;
		logic [31:0] word_asm;
		logic [31:0] decl_len;
		logic [31:0] chunk_rem;
		logic [31:0] chunk_off;
		logic [31:0] chunk_type;
		logic [31:0] size;
		logic        json_ok;
		logic        bin_ok;
		status_t     err;
	} parse_state_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] file_size;
		logic        first_byte;
		logic        last_byte;
	} item_t;

	typedef struct packed {
		kind_t       byte_kind;
		logic [31:0] payload_offset;
		logic [31:0] chunk_kind;
		status_t     status;
		logic        json_found;
		logic        bin_found;
		logic        final_result;
	} result_t;

	localparam parse_state_t STATE_RESET = '{
		phase:      PH_HEADER,
		position:   33'd0,
		word_asm:   32'd0,
		decl_len:   32'd0,
		chunk_rem:  32'd0,
		chunk_off:  32'd0,
		chunk_type: 32'd0,
		size:       32'd0,
		json_ok:    1'b0,
		bin_ok:     1'b0,
		err:        ST_RUN
	};

endpackage

/* rtl/glbd_step.sv */
`timescale 1ns / 1ps
// Per-byte parse step: next parser state and the tag for one container byte.
// Purely combinational; depends on glbd_pkg.
module glbd_step (
	input  glbd_pkg::parse_state_t cur,
	input  glbd_pkg::item_t        item,
	output glbd_pkg::parse_state_t nxt,
	output glbd_pkg::result_t      res
);
	import glbd_pkg::*;

	// A chunk header can start at pos only if all eight of its bytes fit.
	function automatic logic hdr_fits(input logic [32:0] pos, input logic [31:0] dl);
		return ({1'b0, pos} + 34'd8) <= {2'b00, dl};
	endfunction

	function automatic phase_t enter_chunks(input logic [32:0] pos, input logic [31:0] dl);
		return hdr_fits(pos, dl) ? PH_CHDR : PH_TRAIL;
	endfunction

	function automatic phase_t after_payload(input logic [32:0] pos, input logic [31:0] dl);
		phase_t ph;
		if (pos < {1'b0, dl} && pos[1:0] != 2'b00)
			ph = PH_PAD;
		else
			ph = enter_chunks(pos, dl);
		return ph;
	endfunction

	parse_state_t st;
	logic [32:0]  pos;
	logic [32:0]  pos_next;
	logic [31:0]  wa;
	logic [33:0]  chunk_end;

	always_comb begin
		if (item.first_byte) begin
			st      = STATE_RESET;
			st.size = item.file_size;
		end else begin
			st = cur;
		end
		pos       = st.position;
		pos_next  = pos + 33'd1;
		wa        = {item.data_byte, st.word_asm[31:8]};
		chunk_end = {1'b0, pos_next} + {2'b00, st.chunk_rem};

		nxt          = st;
		nxt.word_asm = wa;
		nxt.position = pos_next;

		res                = '0;
		res.byte_kind      = K_IGN;
		res.status         = ST_RUN;
		res.final_result   = item.last_byte;

		case (st.phase)
			PH_HEADER: begin
				res.byte_kind = K_HEADER;
				if (pos == POS_FIRST && st.size < GLB_HDR_LEN) begin
					nxt.err   = ST_SMALL;
					nxt.phase = PH_STOP;
				end else if (pos == POS_MAGIC && wa != GLB_MAGIC) begin
					nxt.err   = ST_MAGIC;
					nxt.phase = PH_STOP;
				end else if (pos == POS_VERSION && wa != GLB_VERSION) begin
					nxt.err   = ST_VERSION;
					nxt.phase = PH_STOP;
				end else if (pos == POS_LENGTH) begin
					if (wa > st.size) begin
						nxt.err   = ST_LENGTH;
						nxt.phase = PH_STOP;
					end else begin
						nxt.decl_len = wa;
						nxt.phase    = enter_chunks(pos_next, wa);
					end
				end
			end
			PH_CHDR: begin
				res.byte_kind = K_CHDR;
				if (st.chunk_off[2:0] == CHDR_TYPE_END) begin
					nxt.chunk_type = wa;
					if (chunk_end > {2'b00, st.decl_len}) begin
						nxt.err   = ST_OVERFLOW;
						nxt.phase = PH_STOP;
					end else begin
						if (wa == GLB_TYPE_JSON)
							nxt.json_ok = st.chunk_rem != 32'd0;
						else if (wa == GLB_TYPE_BIN)
							nxt.bin_ok = st.chunk_rem != 32'd0;
						nxt.chunk_off = 32'd0;
						if (st.chunk_rem == 32'd0)
							nxt.phase = after_payload(pos_next, st.decl_len);
						else
							nxt.phase = PH_PAYLOAD;
					end
				end else begin
					if (st.chunk_off[2:0] == CHDR_LEN_END)
						nxt.chunk_rem = wa;
					nxt.chunk_off = {29'd0, st.chunk_off[2:0] + 3'd1};
				end
			end
			PH_PAYLOAD: begin
				if (st.chunk_type == GLB_TYPE_JSON)
					res.byte_kind = K_JSON;
				else if (st.chunk_type == GLB_TYPE_BIN)
					res.byte_kind = K_BIN;
				else
					res.byte_kind = K_OTHER;
				res.payload_offset = st.chunk_off;
				res.chunk_kind     = st.chunk_type;
				nxt.chunk_off      = st.chunk_off + 32'd1;
				nxt.chunk_rem      = st.chunk_rem - 32'd1;
				if (st.chunk_rem == 32'd1)
					nxt.phase = after_payload(pos_next, st.decl_len);
			end
			PH_PAD: begin
				res.byte_kind  = K_PAD;
				res.chunk_kind = st.chunk_type;
				nxt.phase      = after_payload(pos_next, st.decl_len);
			end
			default: begin
				res.byte_kind = K_IGN;
			end
		endcase

		// Every way into a chunk header starts its byte count over.
		if (nxt.phase == PH_CHDR && st.phase != PH_CHDR)
			nxt.chunk_off = 32'd0;

		if (item.last_byte && nxt.err == ST_RUN) begin
			if (nxt.phase == PH_HEADER)
				nxt.err = ST_SMALL;
			else
				nxt.err = nxt.json_ok ? ST_OK : ST_NO_JSON;
			nxt.phase = PH_STOP;
		end

		res.status     = nxt.err;
		res.json_found = nxt.json_ok;
		res.bin_found  = nxt.bin_ok;
	end

endmodule

/* rtl/glb_container_deframer.sv */
`timescale 1ns / 1ps
// Top level of the GLB container deframer: input register, parser state,
// result register. Depends on glbd_pkg, glbd_step and the assertion header.
//
//  channel | dir | tdata                              | tuser      | tlast
//  --------+-----+------------------------------------+------------+-------------
//  s_*     | in  | data_byte, file_size               | first_byte | last_byte
//  m_*     | out | payload_offset, chunk_kind, status,| byte_kind  | final_result
//          |     | json_found, bin_found              |            |
//
// One byte word per cycle is taken in steady state while m_tready does not stall; a result is
// offered once its byte has passed through the input register and the result register.
// The longest path is a 33-bit increment feeding a 34-bit add and compare.
// arst_n clears the parser state and both valid flags; no clearing pass.
// A stall on m_tready holds the result register; the input register still fills,
// and s_tready drops only when both registers are full.
`include "glb_container_deframer_assert.svh"

module glb_container_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // data_byte[7:0], file_size[39:8]
	input  logic [0:0]  s_tuser,   // first_byte[0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // payload_offset[31:0], chunk_kind[63:32],
	                               // status[66:64], json_found[67], bin_found[68]
	output logic [2:0]  m_tuser,   // byte_kind[2:0]
	output logic        m_tlast
);
	import glbd_pkg::*;

	parse_state_t state_q;
	parse_state_t state_nxt;
	item_t        item_s1;
	logic         valid_s1;
	result_t      res_nxt;
	result_t      res_s2;
	logic         valid_s2;
	logic         adv;
	logic         s_acc;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_acc    = s_tvalid && s_tready;

	glbd_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (s_acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1.data_byte  <= s_tdata[7:0];
			item_s1.file_size  <= s_tdata[39:8];
			item_s1.first_byte <= s_tuser[0];
			item_s1.last_byte  <= s_tlast;
		end
		if (adv)
			res_s2 <= res_nxt;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.byte_kind;
	assign m_tlast  = res_s2.final_result;
	assign m_tdata  = {3'b000, res_s2.bin_found, res_s2.json_found, res_s2.status,
		res_s2.chunk_kind, res_s2.payload_offset};

	`GLBD_ASSERT_IMPL(a_err_stops, state_q.err != ST_RUN, state_q.phase == PH_STOP, "error without stop phase")
	`GLBD_ASSERT_IMPL(a_json_flag, valid_s2 && res_s2.byte_kind == K_JSON, res_s2.json_found && res_s2.chunk_kind == GLB_TYPE_JSON, "JSON byte without JSON chunk")
	`GLBD_ASSERT_IMPL(a_bin_flag, valid_s2 && res_s2.byte_kind == K_BIN, res_s2.bin_found && res_s2.chunk_kind == GLB_TYPE_BIN, "BIN byte without BIN chunk")
	`GLBD_ASSERT_IMPL(a_last_ends, valid_s2 && res_s2.final_result, res_s2.status != ST_RUN, "last byte left parser running")
	`GLBD_ASSERT_NEXT(a_take_holds, s_tvalid && s_tready, valid_s1, "accepted word not held in input register")

endmodule
